FILE: design/accel_dynamic_magnitude_smoother_unit_assert.svh
`ifndef ACCEL_DYNAMIC_MAGNITUDE_SMOOTHER_UNIT_ASSERT_SVH
`define ACCEL_DYNAMIC_MAGNITUDE_SMOOTHER_UNIT_ASSERT_SVH

// same-cycle implication
`define ADMSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ADMSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/admsm_pkg.sv
package admsm_pkg;

  localparam int SAMPLE_FRAC_BITS_DEFAULT = 8;

  localparam int ACCEL_W  = 17;
  localparam int MAG_W    = 17;
  localparam int SUMSQ_W  = 34;
  localparam int GRAV_W   = 16;
  localparam int WEIGHT_W = 17;
  localparam int AVG_W    = 26;
  localparam int AVG_FRAC = 16;
  localparam int OUT_W    = 9;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [GRAV_W-1:0]   GRAV_RESET   = 16'd2510;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd6554;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'h10000;
  localparam logic [OUT_W-1:0]    OUT_MAX      = '1;

  typedef enum logic [1:0] {
    REG_ENABLE  = 2'd0,
    REG_GRAVITY = 2'd1,
    REG_WEIGHT  = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQSUM,
    ST_ROOT,
    ST_EMA,
    ST_FINISH
  } unit_state_t;

  typedef enum logic [2:0] {
    EMA_IDLE,
    EMA_LOAD,
    EMA_MUL,
    EMA_STORE,
    EMA_ROUND
  } ema_phase_t;

  typedef struct packed {
    logic [GRAV_W-1:0]   gravity_offset;
    logic [WEIGHT_W-1:0] smoothing_weight;
  } ema_cfg_t;

endpackage

FILE: design/admsm_sqsum.sv
module admsm_sqsum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [admsm_pkg::ACCEL_W-1:0] accel_x,
  input  logic signed [admsm_pkg::ACCEL_W-1:0] accel_y,
  input  logic signed [admsm_pkg::ACCEL_W-1:0] accel_z,
  output logic [admsm_pkg::SUMSQ_W-1:0]       sum_sq,
  output logic                                done
);
  import admsm_pkg::*;

  localparam int STEPS = MAG_W;
  localparam int CNT_W = $clog2(STEPS);
  localparam int HI_W  = MAG_W + 2;

  function automatic logic [MAG_W-1:0] abs_val(input logic signed [ACCEL_W-1:0] v);
    logic [ACCEL_W-1:0] u;
    u = $unsigned(v);
    abs_val = v[ACCEL_W-1] ? MAG_W'(~u + 1'b1) : MAG_W'(u);
  endfunction

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] mx, my, mz;
  logic [MAG_W-1:0] bx, by, bz;
  logic [HI_W-1:0]  hi;
  logic [MAG_W-1:0] lo;
  logic [HI_W-1:0]  addend;
  logic [HI_W:0]    hi_next;

  assign addend = (bx[0] ? HI_W'(mx) : '0) + (by[0] ? HI_W'(my) : '0)
                + (bz[0] ? HI_W'(mz) : '0);
  assign hi_next = {1'b0, hi} + (HI_W + 1)'(addend);
  assign sum_sq  = SUMSQ_W'({hi, lo});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mx <= abs_val(accel_x);
      my <= abs_val(accel_y);
      mz <= abs_val(accel_z);
      bx <= abs_val(accel_x);
      by <= abs_val(accel_y);
      bz <= abs_val(accel_z);
      hi <= '0;
      lo <= '0;
    end else if (busy) begin
      hi <= hi_next[HI_W:1];
      lo <= {hi_next[0], lo[MAG_W-1:1]};
      bx <= bx >> 1;
      by <= by >> 1;
      bz <= bz >> 1;
    end
  end

endmodule

FILE: design/admsm_isqrt.sv
module admsm_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [admsm_pkg::SUMSQ_W-1:0] radicand,
  output logic [admsm_pkg::MAG_W-1:0]   root,
  output logic                          done
);
  import admsm_pkg::*;

  localparam int STEPS = SUMSQ_W / 2;
  localparam int CNT_W = $clog2(STEPS);
  localparam int REM_W = MAG_W + 1;
  localparam int TRY_W = MAG_W + 3;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [SUMSQ_W-1:0] rad;
  logic [REM_W-1:0]   rem;
  logic [TRY_W-1:0]   rem_sh;
  logic [TRY_W-1:0]   trial;
  logic [TRY_W-1:0]   diff;
  logic               fits;

  assign rem_sh = {rem, rad[SUMSQ_W-1 -: 2]};
  assign trial  = TRY_W'({root, 2'b01});
  assign fits   = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[MAG_W-2:0], fits};
    end
  end

endmodule

FILE: design/admsm_ema.sv
module admsm_ema #(
  parameter int SAMPLE_FRAC_BITS = admsm_pkg::SAMPLE_FRAC_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  admsm_pkg::ema_cfg_t         cfg,
  input  logic [admsm_pkg::MAG_W-1:0] mag,
  output logic [admsm_pkg::OUT_W-1:0] result,
  output logic                        done
);
  import admsm_pkg::*;

  localparam int DYN_SHIFT  = AVG_FRAC - SAMPLE_FRAC_BITS;
  localparam int DYN_WIDE_W = MAG_W + AVG_FRAC;
  localparam int DELTA_W    = AVG_W + 1;
  localparam int ACC_W      = AVG_W + AVG_FRAC + 3;
  localparam int MUL_STEPS  = (WEIGHT_W + 1) / 2;
  localparam int CNT_W      = $clog2(MUL_STEPS);
  localparam int RND_W      = AVG_W + 1;
  localparam int Q_W        = RND_W - AVG_FRAC;

  ema_phase_t phase, phase_next;

  logic                    capture, load, mul, store, round;
  logic [CNT_W-1:0]        cnt;
  logic [AVG_W-1:0]        avg;
  logic [AVG_W-1:0]        dyn;
  logic [WEIGHT_W-1:0]     w_sat;
  logic [WEIGHT_W-1:0]     mult;
  logic signed [ACC_W-1:0] mcand;
  logic signed [ACC_W-1:0] acc;

  logic                    mag_ge;
  logic [MAG_W-1:0]        diff;
  logic [DYN_WIDE_W-1:0]   dyn_wide;
  logic [AVG_W-1:0]        dyn_sat;
  logic [WEIGHT_W-1:0]     w_clip;
  logic signed [DELTA_W-1:0] delta;
  logic signed [ACC_W-1:0] add0, add1;
  logic [RND_W-1:0]        rnd;
  logic [Q_W-1:0]          q;

  assign mag_ge   = mag >= MAG_W'(cfg.gravity_offset);
  assign diff     = mag_ge ? mag - MAG_W'(cfg.gravity_offset)
                           : MAG_W'(cfg.gravity_offset) - mag;
  assign dyn_wide = DYN_WIDE_W'(diff) << DYN_SHIFT;
  assign dyn_sat  = (|dyn_wide[DYN_WIDE_W-1:AVG_W]) ? '1 : dyn_wide[AVG_W-1:0];
  assign w_clip   = (cfg.smoothing_weight > WEIGHT_ONE) ? WEIGHT_ONE
                                                        : cfg.smoothing_weight;
  assign delta    = $signed({1'b0, dyn}) - $signed({1'b0, avg});
  assign add0     = mult[0] ? mcand : '0;
  assign add1     = mult[1] ? (mcand <<< 1) : '0;
  assign rnd      = {1'b0, avg} + RND_W'(1 << (AVG_FRAC - 1));
  assign q        = rnd[RND_W-1:AVG_FRAC];

  always_comb begin
    phase_next = phase;
    unique case (phase)
      EMA_IDLE:  if (start) phase_next = EMA_LOAD;
      EMA_LOAD:  phase_next = EMA_MUL;
      EMA_MUL:   if (cnt == CNT_W'(MUL_STEPS - 1)) phase_next = EMA_STORE;
      EMA_STORE: phase_next = EMA_ROUND;
      EMA_ROUND: phase_next = EMA_IDLE;
      default:   phase_next = EMA_IDLE;
    endcase
  end

  always_comb begin
    capture = (phase == EMA_IDLE) && start;
    load    = (phase == EMA_LOAD);
    mul     = (phase == EMA_MUL);
    store   = (phase == EMA_STORE);
    round   = (phase == EMA_ROUND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= EMA_IDLE;
      cnt   <= '0;
      avg   <= '0;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= round;
      if (load) begin
        cnt <= '0;
      end else if (mul) begin
        cnt <= cnt + 1'b1;
      end
      if (store) begin
        avg <= acc[AVG_FRAC +: AVG_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      dyn   <= dyn_sat;
      w_sat <= w_clip;
    end
    if (load) begin
      mcand <= ACC_W'(delta);
      mult  <= w_sat;
      acc   <= $signed({{(ACC_W - AVG_W - AVG_FRAC){1'b0}}, avg,
                        1'b1, {(AVG_FRAC - 1){1'b0}}});
    end else if (mul) begin
      acc   <= acc + add0 + add1;
      mcand <= mcand <<< 2;
      mult  <= mult >> 2;
    end
    if (round) begin
      result <= (q > Q_W'(OUT_MAX)) ? OUT_MAX : q[OUT_W-1:0];
    end
  end

endmodule

FILE: design/accel_dynamic_magnitude_smoother_unit.sv
// Smoothed dynamic acceleration magnitude. Each accepted word (three signed
// axis samples) is squared and summed by a bit-serial multiplier, rooted by a
// bit-serial square-root unit, compared against the gravity offset and folded
// into an exponential moving average by a radix-4 serial multiplier; the
// average rounded to whole m/s^2 (saturating at 511) is returned. With the
// enable register clear the result is zero and the average is untouched.
// An enabled word runs through 17 steps of the sum-of-squares unit, then
// 17 steps of the square-root unit, then 9 steps of the averaging multiplier.
// A word taken while disabled skips the three units and goes straight to
// the output register. One word is in flight at a time; the next is
// accepted once the result is in the output register, and a stalled output
// holds off the next word.
module accel_dynamic_magnitude_smoother_unit #(
  parameter int SAMPLE_FRAC_BITS = admsm_pkg::SAMPLE_FRAC_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [admsm_pkg::PADDR_W-1:0]       paddr,
  input  logic [admsm_pkg::PDATA_W-1:0]       pwdata,
  output logic [admsm_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [admsm_pkg::ACCEL_W-1:0] accel_x,
  input  logic signed [admsm_pkg::ACCEL_W-1:0] accel_y,
  input  logic signed [admsm_pkg::ACCEL_W-1:0] accel_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [admsm_pkg::OUT_W-1:0]         smoothed_magnitude
);
  import admsm_pkg::*;

  unit_state_t state, state_next;

  logic                sensor_enabled;
  logic [GRAV_W-1:0]   gravity_offset;
  logic [WEIGHT_W-1:0] smoothing_weight;
  reg_index_t          reg_index;
  logic                reg_write;

  logic                sq_start, root_start, ema_start, load_out;
  logic                sq_done, root_done, ema_done;
  logic [SUMSQ_W-1:0]  sum_sq;
  logic [MAG_W-1:0]    mag;
  logic [OUT_W-1:0]    ema_result;
  logic                zero_res;
  ema_cfg_t            ema_cfg;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite;
  assign reg_index = reg_index_t'(paddr[PADDR_W-1:2]);
  assign ema_cfg   = '{gravity_offset: gravity_offset, smoothing_weight: smoothing_weight};

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_enabled   <= 1'b0;
      gravity_offset   <= GRAV_RESET;
      smoothing_weight <= WEIGHT_RESET;
    end else if (reg_write) begin
      unique case (reg_index)
        REG_ENABLE:  sensor_enabled   <= pwdata[0];
        REG_GRAVITY: gravity_offset   <= pwdata[GRAV_W-1:0];
        REG_WEIGHT:  smoothing_weight <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_ENABLE:  prdata = PDATA_W'(sensor_enabled);
      REG_GRAVITY: prdata = PDATA_W'(gravity_offset);
      REG_WEIGHT:  prdata = PDATA_W'(smoothing_weight);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = sensor_enabled ? ST_SQSUM : ST_FINISH;
      ST_SQSUM:  if (sq_done) state_next = ST_ROOT;
      ST_ROOT:   if (root_done) state_next = ST_EMA;
      ST_EMA:    if (ema_done) state_next = ST_FINISH;
      ST_FINISH: if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state != ST_IDLE);
    sq_start   = (state == ST_IDLE) && in_valid && sensor_enabled;
    root_start = (state == ST_SQSUM) && sq_done;
    ema_start  = (state == ST_ROOT) && root_done;
    load_out   = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      zero_res  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_IDLE) && in_valid) begin
        zero_res <= !sensor_enabled;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      smoothed_magnitude <= zero_res ? '0 : ema_result;
    end
  end

  admsm_sqsum u_sqsum (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .sum_sq  (sum_sq),
    .done    (sq_done)
  );

  admsm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sum_sq),
    .root     (mag),
    .done     (root_done)
  );

  admsm_ema #(
    .SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
  ) u_ema (
    .clk    (clk),
    .rst    (rst),
    .start  (ema_start),
    .cfg    (ema_cfg),
    .mag    (mag),
    .result (ema_result),
    .done   (ema_done)
  );

endmodule

FILE: design/admsm_checker.sv
`include "accel_dynamic_magnitude_smoother_unit_assert.svh"

module admsm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [admsm_pkg::OUT_W-1:0] smoothed_magnitude
);

  `ADMSM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped while stalled")
  `ADMSM_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(smoothed_magnitude), "stalled result changed")
  `ADMSM_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall, "second word taken while one is in flight")
  `ADMSM_ASSERT_NOW(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall), "result appeared without a word in flight")

endmodule

bind accel_dynamic_magnitude_smoother_unit admsm_checker u_admsm_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .smoothed_magnitude (smoothed_magnitude)
);

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import admsm_pkg::*;

  localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 4'd12;
  localparam int LONG_HOLD = 400;
  localparam int PHASES = 11;
  localparam int PHASE_WORDS = 118;
  localparam int DIRECTED_WORDS = 12;
  localparam int DISABLED_WORDS = 5;

  class magnitude_tracker;
    logic                enabled = 1'b0;
    logic [GRAV_W-1:0]   gravity = GRAV_RESET;
    logic [WEIGHT_W-1:0] weight = WEIGHT_RESET;
    logic [AVG_W-1:0]    average = '0;
    logic [OUT_W-1:0]    expected_magnitudes[$];
    int                  mismatches = 0;

    function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at %0t: %s", $time, what);
      end
    endfunction

    function void write_register(reg_index_t idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_ENABLE:  enabled = value[0];
        REG_GRAVITY: gravity = value[GRAV_W-1:0];
        REG_WEIGHT:  weight = value[WEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PDATA_W-1:0] register_value(reg_index_t idx);
      case (idx)
        REG_ENABLE:  return PDATA_W'(enabled);
        REG_GRAVITY: return PDATA_W'(gravity);
        REG_WEIGHT:  return PDATA_W'(weight);
        default:     return '0;
      endcase
    endfunction

    function void check_register(reg_index_t idx, logic [PDATA_W-1:0] actual);
      logic [PDATA_W-1:0] want;
      want = register_value(idx);
      if (actual !== want) begin
        note_mismatch($sformatf("register %s: expected %0d, got %0d",
                                idx.name(), want, actual));
      end
    endfunction

    function longint unsigned axis_abs(logic signed [ACCEL_W-1:0] v);
      longint s;
      s = 64'(v);
      return (s < 0) ? -s : s;
    endfunction

    function longint unsigned floor_root(longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 17; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= n) begin
          root = trial;
        end
      end
      return root;
    endfunction

    function void note_sample(logic signed [ACCEL_W-1:0] x, y, z);
      longint unsigned ax, ay, az, mag, dyn, w, acc, rounded;
      if (!enabled) begin
        expected_magnitudes.push_back('0);
        return;
      end
      ax = axis_abs(x);
      ay = axis_abs(y);
      az = axis_abs(z);
      mag = floor_root(ax * ax + ay * ay + az * az);
      dyn = (mag >= gravity) ? mag - gravity : gravity - mag;
      dyn = dyn << (AVG_FRAC - SAMPLE_FRAC_BITS_DEFAULT);
      if (dyn > (64'd1 << AVG_W) - 1) begin
        dyn = (64'd1 << AVG_W) - 1;
      end
      w = 64'((weight > WEIGHT_ONE) ? WEIGHT_ONE : weight);
      acc = w * dyn + ((64'd1 << AVG_FRAC) - w) * average + (64'd1 << (AVG_FRAC - 1));
      average = AVG_W'(acc >> AVG_FRAC);
      rounded = (average + (64'd1 << (AVG_FRAC - 1))) >> AVG_FRAC;
      if (rounded > OUT_MAX) begin
        rounded = 64'(OUT_MAX);
      end
      expected_magnitudes.push_back(OUT_W'(rounded));
    endfunction

    function void check_magnitude(logic [OUT_W-1:0] actual);
      logic [OUT_W-1:0] want;
      if (expected_magnitudes.size() == 0) begin
        note_mismatch($sformatf("smoothed_magnitude %0d with nothing pending", actual));
        return;
      end
      want = expected_magnitudes.pop_front();
      if (actual !== want) begin
        note_mismatch($sformatf("smoothed_magnitude: expected %0d, got %0d", want, actual));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ACCEL_W-1:0] accel_x = '0;
  logic signed [ACCEL_W-1:0] accel_y = '0;
  logic signed [ACCEL_W-1:0] accel_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [OUT_W-1:0] smoothed_magnitude;

  magnitude_tracker tracker = new;
  int burst_left = 0;
  int hold_requests = 0;
  int holds_done = 0;

  int directed_axes [DIRECTED_WORDS][3] = '{
    '{0, 0, 0},
    '{65535, 65535, 65535},
    '{-65536, -65536, -65536},
    '{-65536, 0, 0},
    '{0, 65535, 0},
    '{0, 0, -65536},
    '{2510, 0, 0},
    '{0, -2509, 0},
    '{1506, -2008, 0},
    '{-1, -1, -1},
    '{1, 0, 0},
    '{65535, -65536, 65535}
  };

  accel_dynamic_magnitude_smoother_unit dut (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .accel_x           (accel_x),
    .accel_y           (accel_y),
    .accel_z           (accel_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .smoothed_magnitude(smoothed_magnitude)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("accel_dynamic_magnitude_smoother_unit regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_magnitude(smoothed_magnitude);
    end
  end

  // receiver: stall patterns of varying density, long hold on request
  initial begin
    int span;
    int stall_pct;
    @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        span = $urandom_range(1, 60);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        repeat (span) begin
          out_stall <= ($urandom_range(0, 99) < stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_register(reg_index_t idx, logic [PDATA_W-1:0] value);
    apb_write({idx, 2'b00}, value);
    tracker.write_register(idx, value);
  endtask

  task automatic verify_registers();
    logic [PDATA_W-1:0] data;
    apb_read({REG_ENABLE, 2'b00}, data);
    tracker.check_register(REG_ENABLE, data);
    apb_read({REG_GRAVITY, 2'b00}, data);
    tracker.check_register(REG_GRAVITY, data);
    apb_read({REG_WEIGHT, 2'b00}, data);
    tracker.check_register(REG_WEIGHT, data);
  endtask

  task automatic offer_sample(logic signed [ACCEL_W-1:0] x, y, z);
    int gap;
    in_valid <= 1'b1;
    accel_x <= x;
    accel_y <= y;
    accel_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_sample(x, y, z);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_magnitudes.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [ACCEL_W-1:0] pick_axis(int kind);
    int v;
    case (kind)
      0: return ACCEL_W'($urandom);
      1: begin
        v = $urandom_range(0, 3000);
        return ACCEL_W'($urandom_range(0, 1) ? -v : v);
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return ACCEL_W'(-65536);
          1: return ACCEL_W'(65535);
          2: return '0;
          default: return '1;
        endcase
      end
      default: return ACCEL_W'($urandom_range(0, 128) - 64);
    endcase
  endfunction

  initial begin
    int kind;
    int pick;
    logic en;
    logic [GRAV_W-1:0] grav;
    logic [WEIGHT_W-1:0] w;
    logic [PDATA_W-1:0] noise;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    verify_registers();
    for (int i = 0; i < DISABLED_WORDS; i++) begin
      offer_sample(ACCEL_W'(directed_axes[i][0]), ACCEL_W'(directed_axes[i][1]),
                   ACCEL_W'(directed_axes[i][2]));
    end
    drain();
    set_register(REG_ENABLE, 32'd1);
    verify_registers();
    for (int i = 0; i < DIRECTED_WORDS; i++) begin
      offer_sample(ACCEL_W'(directed_axes[i][0]), ACCEL_W'(directed_axes[i][1]),
                   ACCEL_W'(directed_axes[i][2]));
    end
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin en = 1'b1; grav = GRAV_RESET; w = WEIGHT_RESET; end
        1: begin en = 1'b1; grav = '0; w = WEIGHT_ONE; end
        2: begin en = 1'b1; grav = '1; w = '0; end
        3: begin en = 1'b1; grav = GRAV_RESET; w = '1; end
        4: begin en = 1'b0; grav = GRAV_W'($urandom); w = WEIGHT_W'($urandom); end
        5: begin en = 1'b1; grav = '0; w = 17'd1; end
        default: begin
          en = ($urandom_range(0, 9) != 0);
          grav = GRAV_W'($urandom_range(0, 1) ? $urandom_range(2000, 3000)
                                              : $urandom_range(0, 65535));
          case ($urandom_range(0, 3))
            0: w = WEIGHT_W'($urandom_range(1, 8000));
            1: w = WEIGHT_ONE;
            default: w = WEIGHT_W'($urandom_range(0, 131071));
          endcase
        end
      endcase
      noise = $urandom;
      set_register(REG_ENABLE, {noise[31:1], en});
      noise = $urandom;
      set_register(REG_GRAVITY, {noise[31:16], grav});
      noise = $urandom;
      set_register(REG_WEIGHT, {noise[31:17], w});
      apb_write(UNMAPPED_ADDR, $urandom);
      verify_registers();

      if (phase == 1 || phase == 7) begin
        hold_requests++;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 5 && n == PHASE_WORDS / 2) begin
          drain();
        end
        pick = $urandom_range(0, 9);
        kind = (pick < 4) ? 0 : (pick < 8) ? 1 : (pick == 8) ? 2 : 3;
        offer_sample(pick_axis(kind), pick_axis(kind), pick_axis(kind));
      end
      drain();
    end

    repeat (64) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_magnitudes.size() == 0) begin
      $display("accel_dynamic_magnitude_smoother_unit regression: pass");
    end else begin
      $display("accel_dynamic_magnitude_smoother_unit regression: fail");
    end
    $finish;
  end

endmodule
